### rtl/ptbs_pkg.sv
// Shared constants for the packed table binary search block.
package ptbs_pkg;

	localparam int MEM_BYTES      = 65536;
	localparam int MAX_ENTRIES    = 16384;
	localparam int MEM_AW         = $clog2(MEM_BYTES);

	localparam int BITS_PER_ENTRY = 25;
	localparam int CODE_W         = 5;
	localparam int LETTERS        = 5;
	localparam int GROUP_W        = 32;
	localparam int WORD_W         = 40;
	localparam int SKIP_W         = 3;

	localparam logic [CODE_W-1:0] CODE_MASK   = 5'h1F;
	localparam logic [7:0]        LETTER_BASE = 8'h41;

	localparam int CNT_W  = 15;
	localparam int BASE_W = 16;
	// signed search bounds: index range plus a sign bit
	localparam int IDX_W  = $clog2(MAX_ENTRIES) + 2;
	// unsigned midpoint
	localparam int MID_W  = IDX_W - 1;
	// bit position of an entry in the packed table
	localparam int BPOS_W = MID_W + 5;
	// byte address of a probe, one bit of headroom for overflow
	localparam int ADDR_W = BASE_W + 1;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic REG_ENTRY_COUNT = 1'b0;
	localparam logic REG_TABLE_BASE  = 1'b1;

endpackage

### rtl/packed_table_binary_search.sv
// Top level: byte memory, configuration registers and the binary search sequencer.
//
// Holds a 64 KiB byte memory with a sorted table of five-letter words packed
// at 25 bits each (5 bits a letter, first letter highest). A load transfer
// (tuser = 0) writes one byte and gives no result. A query transfer (tuser = 1)
// binary-searches entry_count entries, clamped to 16384, from table_base and
// returns one result byte: bit 0 found, bit 1 fault (a probe reached past the
// end of memory). The input side takes nothing else while a query runs. After
// the query transfer a start step sets up the bounds, then each probe runs
// midpoint, address, four byte reads through the single registered memory
// read port plus a final capture, and one 40-bit compare. A search that runs
// out of window finds it closed at the midpoint step, and a done step loads
// the result register. A search makes up to 15 probes, fewer on an early match
// or a fault; the probe count and the byte-serial reads set the time. The
// input is ready again in the same cycle that the result becomes valid. The
// result sits in an output register, so the next transfer can be taken while
// it waits. The memory has no reset; entries must be loaded before they are
// searched. Configuration writes are taken at any time and must only be
// issued while the block is idle.
module packed_table_binary_search (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // byte_addr[15:0], byte_value[23:16], query_word[63:24]
	input  logic        s_tuser,  // cmd: 0 load byte, 1 query
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // found[0], fault[1], zero[7:2]
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,  // 0 entry_count, 1 table_base
	input  logic [15:0] cfg_data
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_START = 7'b0000010,
		ST_PROBE = 7'b0000100,
		ST_ADDR  = 7'b0001000,
		ST_READ  = 7'b0010000,
		ST_CMP   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration
	logic [ptbs_pkg::CNT_W-1:0]  entry_count_q;
	logic [ptbs_pkg::BASE_W-1:0] table_base_q;

	// input fields
	logic [15:0]                 in_byte_addr;
	logic [7:0]                  in_byte_value;
	logic [ptbs_pkg::WORD_W-1:0] in_query;
	logic                        s_xfer;

	// search state
	logic [ptbs_pkg::WORD_W-1:0]        query_q;
	logic signed [ptbs_pkg::IDX_W-1:0]  lo_q;
	logic signed [ptbs_pkg::IDX_W-1:0]  hi_q;
	logic [ptbs_pkg::MID_W-1:0]         mid_q;
	logic [ptbs_pkg::ADDR_W-1:0]        addr_q;
	logic [ptbs_pkg::SKIP_W-1:0]        skip_q;
	logic [2:0]                         rd_cnt_q;
	logic [ptbs_pkg::GROUP_W-1:0]       group_q;
	logic                               found_q;
	logic                               fault_q;

	// result register
	logic m_tvalid_q;
	logic res_found_q;
	logic res_fault_q;

	// memory
	logic [7:0]                  mem [ptbs_pkg::MEM_BYTES];
	logic [ptbs_pkg::MEM_AW-1:0] rd_addr;
	logic [7:0]                  rdata_q;

	// datapath
	logic [ptbs_pkg::MID_W-1:0]         cnt_clamp;
	logic signed [ptbs_pkg::IDX_W-1:0]  bound_sum;
	logic [ptbs_pkg::BPOS_W-1:0]        bit_pos;
	logic [ptbs_pkg::ADDR_W-1:0]        probe_addr;
	logic [ptbs_pkg::ADDR_W:0]          probe_last;
	logic                               probe_oob;
	logic [ptbs_pkg::WORD_W-1:0]        entry_word;
	logic signed [ptbs_pkg::IDX_W-1:0]  mid_s;

	assign in_byte_addr  = s_tdata[15:0];
	assign in_byte_value = s_tdata[23:16];
	assign in_query      = s_tdata[63:24];

	assign s_tready  = (state_q == ST_IDLE);
	assign s_xfer    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b000000, res_fault_q, res_found_q};

	// counts above the table limit are clamped
	assign cnt_clamp = (32'(entry_count_q) > ptbs_pkg::MAX_ENTRIES) ?
		ptbs_pkg::MID_W'(ptbs_pkg::MAX_ENTRIES) : ptbs_pkg::MID_W'(entry_count_q);

	// both bounds are non-negative whenever the window is open
	assign bound_sum = lo_q + hi_q;

	// mid * 25 as shift-and-add
	assign bit_pos = {1'b0, mid_q, 4'b0000} + {2'b00, mid_q, 3'b000} +
		ptbs_pkg::BPOS_W'(mid_q);
	assign probe_addr = {1'b0, table_base_q} +
		ptbs_pkg::ADDR_W'(bit_pos[ptbs_pkg::BPOS_W-1:3]);
	assign probe_last = {1'b0, probe_addr} + (ptbs_pkg::ADDR_W + 1)'(3);
	assign probe_oob  = (32'(probe_last) >= ptbs_pkg::MEM_BYTES);

	assign mid_s   = signed'({1'b0, mid_q});
	assign rd_addr = addr_q[ptbs_pkg::MEM_AW-1:0] + ptbs_pkg::MEM_AW'(rd_cnt_q[1:0]);

	ptbs_unpack u_unpack (
		.group (group_q),
		.skip  (skip_q),
		.word  (entry_word)
	);

	// byte memory: one write port for loads, one registered read port for probes
	always_ff @(posedge clk) begin
		if (s_xfer && (s_tuser == ptbs_pkg::CMD_LOAD) &&
				(32'(in_byte_addr) < ptbs_pkg::MEM_BYTES)) begin
			mem[ptbs_pkg::MEM_AW'(in_byte_addr)] <= in_byte_value;
		end
		rdata_q <= mem[rd_addr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			table_base_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ptbs_pkg::REG_ENTRY_COUNT: entry_count_q <= cfg_data[ptbs_pkg::CNT_W-1:0];
				ptbs_pkg::REG_TABLE_BASE:  table_base_q  <= cfg_data[ptbs_pkg::BASE_W-1:0];
				default: ;
			endcase
		end
	end

	// search payload, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				query_q <= in_query;
			end
			ST_START: begin
				lo_q    <= '0;
				hi_q    <= signed'({1'b0, cnt_clamp}) - ptbs_pkg::IDX_W'(1);
				found_q <= 1'b0;
				fault_q <= 1'b0;
			end
			ST_PROBE: begin
				mid_q <= bound_sum[ptbs_pkg::IDX_W-1:1];
			end
			ST_ADDR: begin
				addr_q   <= probe_addr;
				skip_q   <= bit_pos[2:0];
				rd_cnt_q <= '0;
				fault_q  <= probe_oob;
			end
			ST_READ: begin
				rd_cnt_q <= rd_cnt_q + 3'd1;
				// read data comes from the registered read port, trailing its address
				if (rd_cnt_q != 3'd0) begin
					group_q <= {group_q[ptbs_pkg::GROUP_W-9:0], rdata_q};
				end
			end
			ST_CMP: begin
				if (query_q == entry_word) begin
					found_q <= 1'b1;
				end else if (query_q < entry_word) begin
					hi_q <= mid_s - ptbs_pkg::IDX_W'(1);
				end else begin
					lo_q <= mid_s + ptbs_pkg::IDX_W'(1);
				end
			end
			default: ;
		endcase
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			m_tvalid_q  <= 1'b0;
			res_found_q <= 1'b0;
			res_fault_q <= 1'b0;
		end else begin
			// in ST_DONE the result load below owns the output register
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_xfer && (s_tuser == ptbs_pkg::CMD_QUERY)) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= (cnt_clamp == '0) ? ST_DONE : ST_PROBE;
				end
				ST_PROBE: begin
					// window closed: not found
					state_q <= (lo_q > hi_q) ? ST_DONE : ST_ADDR;
				end
				ST_ADDR: begin
					state_q <= probe_oob ? ST_DONE : ST_READ;
				end
				ST_READ: begin
					if (rd_cnt_q == 3'd4) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= (query_q == entry_word) ? ST_DONE : ST_PROBE;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q  <= 1'b1;
						res_found_q <= found_q;
						res_fault_q <= fault_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a result never reports both a match and a fault
	a_found_fault_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !(res_found_q && res_fault_q))
		else $error("found and fault both set");

	// reads only happen inside an open search window
	a_read_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (lo_q <= hi_q) && (lo_q >= 0))
		else $error("probe outside search window");

	// midpoint lies between the bounds
	a_mid_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADDR) |-> (mid_s >= lo_q) && (mid_s <= hi_q))
		else $error("midpoint outside bounds");

	// probe reads stay inside memory
	a_read_in_mem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (32'(addr_q) + 3 < ptbs_pkg::MEM_BYTES))
		else $error("probe read past memory");

	// a finished result holds while the output register is occupied
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && m_tvalid_q && !m_tready |=> (state_q == ST_DONE))
		else $error("result overwrote pending output");

endmodule

### rtl/ptbs_unpack.sv
// Extracts one 25-bit packed entry from a 32-bit group and expands it to ASCII.
module ptbs_unpack (
	input  logic [ptbs_pkg::GROUP_W-1:0] group,
	input  logic [ptbs_pkg::SKIP_W-1:0]  skip,
	output logic [ptbs_pkg::WORD_W-1:0]  word
);

	logic [ptbs_pkg::GROUP_W-1:0]        shifted;
	logic [ptbs_pkg::BITS_PER_ENTRY-1:0] field;

	// entry starts skip bits below the top of the group
	assign shifted = group >> (ptbs_pkg::SKIP_W'(7) - skip);
	assign field   = shifted[ptbs_pkg::BITS_PER_ENTRY-1:0];

	always_comb begin
		for (int i = 0; i < ptbs_pkg::LETTERS; i++) begin
			word[ptbs_pkg::WORD_W-1-8*i -: 8] =
				{3'b000, field[ptbs_pkg::BITS_PER_ENTRY-1-ptbs_pkg::CODE_W*i -: ptbs_pkg::CODE_W]
					& ptbs_pkg::CODE_MASK} + ptbs_pkg::LETTER_BASE;
		end
	end

endmodule

### dv/tb_packed_table_binary_search.sv
// Self-checking testbench for packed_table_binary_search: lookup scoreboard and top module.

class word_search_sb;
	typedef struct packed {
		bit found;
		bit fault;
	} answer_t;

	logic [7:0] mem [ptbs_pkg::MEM_BYTES];
	bit         marks [ptbs_pkg::MEM_BYTES];	// byte loaded since the last table change
	bit [14:0]  entry_count;
	bit [15:0]  table_base;
	answer_t    pending_answers[$];
	int         failures = 0;
	int         queries = 0;
	int         loads = 0;
	int         hits = 0;
	int         faults = 0;
	int         results = 0;

	function new();
		entry_count = '0;
		table_base = '0;
	endfunction

	function void set_reg(logic idx, logic [15:0] data);
		if (idx == ptbs_pkg::REG_ENTRY_COUNT)
			entry_count = data[14:0];
		else
			table_base = data;
	endfunction

	function void clear_marks();
		foreach (marks[i])
			marks[i] = 1'b0;
	endfunction

	// Walks the binary search. With plan set it stops at the first probe that
	// touches a byte not loaded yet and hands back that probe's address in gap.
	function void search(bit [39:0] word, bit plan, output bit found, output bit fault,
			output int gap);
		int        lo, hi, mid, bpos, addr, skip, cnt;
		bit [31:0] grp;
		bit [39:0] entry;
		bit [4:0]  code;
		found = 1'b0;
		fault = 1'b0;
		gap = -1;
		cnt = (entry_count > ptbs_pkg::MAX_ENTRIES) ? ptbs_pkg::MAX_ENTRIES : entry_count;
		lo = 0;
		hi = cnt - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			bpos = mid * ptbs_pkg::BITS_PER_ENTRY;
			addr = table_base + (bpos >> 3);
			skip = bpos & 7;
			if (addr + 3 >= ptbs_pkg::MEM_BYTES) begin
				fault = 1'b1;
				return;
			end
			if (plan && !(marks[addr] && marks[addr+1] && marks[addr+2] && marks[addr+3])) begin
				gap = addr;
				return;
			end
			grp = {mem[addr], mem[addr+1], mem[addr+2], mem[addr+3]};
			entry = '0;
			for (int i = 0; i < 5; i++) begin
				code = 5'(grp >> (32 - (skip + (i + 1) * 5)));
				entry = {entry[31:0], {3'b000, code} + ptbs_pkg::LETTER_BASE};
			end
			if (word == entry) begin
				found = 1'b1;
				return;
			end
			if (word < entry)
				hi = mid - 1;
			else
				lo = mid + 1;
		end
	endfunction

	function void note_input(bit cmd, bit [15:0] addr, bit [7:0] val, bit [39:0] word);
		answer_t a;
		bit      f, x;
		int      gap;
		if (cmd == ptbs_pkg::CMD_LOAD) begin
			mem[addr] = val;
			marks[addr] = 1'b1;
			loads++;
		end else begin
			search(word, 1'b0, f, x, gap);
			a.found = f;
			a.fault = x;
			pending_answers.push_back(a);
			queries++;
			hits += f;
			faults += x;
		end
	endfunction

	function void check_result(bit found, bit fault);
		answer_t a;
		results++;
		if (pending_answers.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("result %0d with no lookup outstanding: found=%0b fault=%0b",
					results, found, fault);
			return;
		end
		a = pending_answers.pop_front();
		if (a.found != found || a.fault != fault) begin
			failures++;
			if (failures <= 10)
				$display("result %0d mismatch: expected found=%0b fault=%0b, got found=%0b fault=%0b",
					results, a.found, a.fault, found, fault);
		end
	endfunction
endclass

module tb_packed_table_binary_search;

	localparam int WATCHDOG_LIMIT = 3000;	// covers the slowest lookup plus long stalls
	localparam int ITEM_BUDGET    = 1800;
	localparam int PHASE_ITEMS    = 150;
	localparam int CFG_SETTLE     = 8;	// a load gives no result to wait for
	localparam int DRAIN_CYCLES   = 120;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [63:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tready = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;
	wire         s_tready, m_tvalid, cfg_ready;
	wire  [7:0]  m_tdata;

	word_search_sb sb;
	int            send_idle_pct = 15;
	int            recv_idle_pct = 69;
	int            items_sent = 0;
	int            idle_cycles = 0;
	int            phases_run = 0;
	int            cur_base = 0;
	bit [24:0]     tbl_codes[$];	// sorted letter codes of the table now configured

	packed_table_binary_search u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// result side back-pressure, redrawn every cycle
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// result checking and watchdog; a cycle with any transfer resets the count
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata[0], m_tdata[1]);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("watchdog: no transfer for %0d cycles, %0d answers outstanding",
						idle_cycles, sb.pending_answers.size());
					$display("RESULT: ERROR");
					$finish;
				end
			end
		end
	end

	function automatic bit [39:0] rand40();
		bit [63:0] r;
		r = {$urandom, $urandom};
		return r[39:0];
	endfunction

	// five 5-bit codes to ASCII, first letter in the top byte
	function automatic bit [39:0] to_ascii(bit [24:0] c);
		bit [39:0] w;
		w = '0;
		for (int i = 0; i < 5; i++)
			w = {w[31:0], {3'b000, c[24-5*i -: 5]} + ptbs_pkg::LETTER_BASE};
		return w;
	endfunction

	// byte at offset off of the packed bit stream of tbl_codes, MSB first
	function automatic bit [7:0] tbl_byte(int off);
		int       bpos, e;
		bit [7:0] b;
		b = '0;
		for (int k = 0; k < 8; k++) begin
			bpos = off * 8 + k;
			e = bpos / ptbs_pkg::BITS_PER_ENTRY;
			b = {b[6:0], (e < tbl_codes.size()) ?
				tbl_codes[e][24 - bpos % ptbs_pkg::BITS_PER_ENTRY] : 1'b0};
		end
		return b;
	endfunction

	// One transfer on the input stream; entered and left at a falling edge.
	// valid stays high into the next call unless that call idles first.
	task automatic send_item(bit cmd, bit [15:0] addr, bit [7:0] val, bit [39:0] word);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = cmd;
		s_tdata = {word, val, addr};
		do @(posedge clk); while (!s_tready);
		sb.note_input(cmd, addr, val, word);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic load_byte(int addr, bit [7:0] val);
		send_item(ptbs_pkg::CMD_LOAD, addr[15:0], val, rand40());
	endtask

	// Loads whatever table bytes the search path still lacks, then sends the lookup.
	// Only probes that are really made get loaded, so big tables stay cheap.
	task automatic lookup(bit [39:0] word);
		bit [31:0] r;
		bit        f, x;
		int        gap;
		r = $urandom;
		forever begin
			sb.search(word, 1'b1, f, x, gap);
			if (gap < 0)
				break;
			for (int j = 0; j < 4; j++)
				if (!sb.marks[gap + j])
					load_byte(gap + j, tbl_byte(gap + j - cur_base));
		end
		send_item(ptbs_pkg::CMD_QUERY, r[15:0], r[23:16], word);
	endtask

	task automatic write_reg(logic idx, logic [15:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Registers only change with the block idle: all answers back, then a short pause.
	// Draws a fresh sorted table of the effective size.
	task automatic new_table(bit [15:0] count_data, int base);
		int        n, step;
		bit [24:0] code;
		s_tvalid = 1'b0;
		while (sb.pending_answers.size() != 0)
			@(negedge clk);
		repeat (CFG_SETTLE) @(negedge clk);
		write_reg(ptbs_pkg::REG_ENTRY_COUNT, count_data);
		write_reg(ptbs_pkg::REG_TABLE_BASE, base[15:0]);
		sb.clear_marks();
		cur_base = base;
		n = (count_data[14:0] > ptbs_pkg::MAX_ENTRIES) ? ptbs_pkg::MAX_ENTRIES :
			count_data[14:0];
		tbl_codes.delete();
		if (n > 0) begin
			step = (1 << 25) / (n + 1);
			code = 25'($urandom_range(step - 1));
			for (int i = 0; i < n; i++) begin
				tbl_codes.push_back(code);
				code += 25'($urandom_range(step, 1));
			end
		end
		phases_run++;
	endtask

	// Mostly table members and near misses; the rest off either end or pure noise.
	task automatic random_lookup();
		int        n, pick;
		bit [24:0] c;
		bit [39:0] w;
		n = tbl_codes.size();
		pick = $urandom_range(99);
		if (n > 0 && pick < 45) begin
			w = to_ascii(tbl_codes[$urandom_range(n - 1)]);
		end else if (n > 0 && pick < 60) begin
			c = tbl_codes[$urandom_range(n - 1)];
			c = $urandom_range(1) ? c + 1'b1 : c - 1'b1;
			w = to_ascii(c);
		end else if (pick < 70) begin
			w = rand40();
		end else if (pick < 80) begin
			w = rand40();
			w[39:32] = 8'($urandom_range(8'h40));
		end else if (pick < 90) begin
			w = rand40();
			w[39:32] = 8'($urandom_range(255, 8'h61));
		end else begin
			c = 25'($urandom);
			w = to_ascii(c);
		end
		lookup(w);
	endtask

	initial begin
		int          start, phase_end, done, n, span, base, r;
		bit [15:0]   count_data;
		sb = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed part ---
		// empty table straight after reset, plus loads at both ends of memory
		lookup(to_ascii(25'h0));
		lookup(rand40());
		load_byte(0, 8'hFF);
		load_byte(ptbs_pkg::MEM_BYTES - 1, 8'h00);

		// extreme letter codes: all 'A' and all '`', then misses between and off both ends
		new_table(16'd2, 7);
		tbl_codes = '{25'h0000000, 25'h1FFFFFF};
		lookup(to_ascii(25'h0000000));
		lookup(to_ascii(25'h1FFFFFF));
		lookup(to_ascii(25'h0ABCDEF));
		lookup(40'h00_0000_0000);
		lookup(40'hFF_FFFF_FFFF);

		// single entry at the top byte: first probe already runs off the end
		new_table(16'd1, ptbs_pkg::MEM_BYTES - 1);
		lookup(to_ascii(tbl_codes[0]));

		// table straddling the end: low entries found, high ones fault,
		// below entry zero ends cleanly
		new_table(16'd40, ptbs_pkg::MEM_BYTES - 106);
		lookup(to_ascii(tbl_codes[0]));
		lookup(to_ascii(tbl_codes[39]));
		lookup(to_ascii(tbl_codes[20]));
		lookup(to_ascii(tbl_codes[0] - 1'b1));

		// --- random part ---
		// first two settings are fixed: full table from zero, then an oversized
		// count whose upper entries run past memory
		start = items_sent;
		while (items_sent - start < ITEM_BUDGET) begin
			if (phases_run == 3) begin
				count_data = 16'd16384;
				base = 0;
			end else if (phases_run == 4) begin
				count_data = 16'hFFFF;
				base = 20000;
			end else begin
				r = $urandom_range(99);
				if (r < 5)
					count_data = 16'd0;
				else if (r < 70)
					count_data = 16'($urandom_range(48, 1));
				else if (r < 85)
					count_data = 16'($urandom_range(2000, 49));
				else
					count_data = 16'($urandom_range(32767, 2001));
				count_data[15] = 1'($urandom_range(1));
				n = (count_data[14:0] > ptbs_pkg::MAX_ENTRIES) ? ptbs_pkg::MAX_ENTRIES :
					count_data[14:0];
				span = (n * ptbs_pkg::BITS_PER_ENTRY + 7) / 8 + 4;
				if ($urandom_range(99) < 75)
					base = $urandom_range(ptbs_pkg::MEM_BYTES - span);
				else
					base = $urandom_range(ptbs_pkg::MEM_BYTES - 1);
			end
			new_table(count_data, base);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end && items_sent - start < ITEM_BUDGET) begin
				// idling regimes by progress: slow receiver, then slow sender, then flat out
				done = items_sent - start;
				if (done < ITEM_BUDGET / 3) begin
					send_idle_pct = 15;
					recv_idle_pct = 69;
				end else if (done < 2 * ITEM_BUDGET / 3) begin
					send_idle_pct = 69;
					recv_idle_pct = 15;
				end else begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				// stray loads anywhere, table bytes included
				if ($urandom_range(99) < 8)
					load_byte($urandom_range(ptbs_pkg::MEM_BYTES - 1), 8'($urandom_range(255)));
				else
					random_lookup();
			end
		end

		// drain: every answer back, then a quiet spell for anything stray
		s_tvalid = 1'b0;
		while (sb.pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d table settings with %0d byte loads and %0d word lookups.",
			phases_run, sb.loads, sb.queries);
		$display("Lookups gave %0d hits and %0d probe faults; %0d answers checked, %0d failures.",
			sb.hits, sb.faults, sb.results, sb.failures);
		if (sb.failures == 0 && sb.pending_answers.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### sim.f
rtl/ptbs_pkg.sv
rtl/ptbs_unpack.sv
rtl/packed_table_binary_search.sv
dv/tb_packed_table_binary_search.sv
